### design/apool_pkg.sv
`timescale 1ns / 1ps
// Shared constants and register codes for the 1-D average pooling block.
package apool_pkg;

   localparam int unsigned MAX_KERNEL_DEF   = 64;
   localparam int unsigned MAX_CHANNELS_DEF = 16;
   localparam int unsigned MAX_WIDTH        = 4096;
   localparam int unsigned MAX_STRIDE       = 64;
   localparam int unsigned SAMPLE_BITS      = 16;

   localparam int unsigned POS_W      = $clog2(MAX_WIDTH);
   localparam int unsigned PHASE_W    = $clog2(MAX_STRIDE);
   localparam int unsigned CFG_W      = 7;
   localparam int unsigned CHCNT_W    = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CHAN_OUT_W = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KERNEL_SIZE   = 2'd0,
      REG_STRIDE        = 2'd1,
      REG_CHANNEL_COUNT = 2'd2
   } csr_index_type;

endpackage

### design/apool_div.sv
`timescale 1ns / 1ps
// Bit-serial signed divider: window sum over kernel size, truncated toward zero.
module apool_div #(
   parameter int unsigned SUM_W = apool_pkg::SAMPLE_BITS + 6,
   parameter int unsigned Q_W   = apool_pkg::SAMPLE_BITS,
   parameter int unsigned K_W   = apool_pkg::CFG_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic        [K_W-1:0]   divisor,
   output logic                    done,
   output logic signed [Q_W-1:0]   quotient
);

   localparam int unsigned CNT_W = $clog2(SUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [K_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0] mag_ff, mag_in;
   logic [K_W-1:0]   dvs_ff, dvs_in;
   logic             neg_ff, neg_in;
   logic [K_W:0]     trial;
   logic [K_W:0]     diff;
   logic             qbit;
   logic [SUM_W-1:0] q_signed;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      mag_in  = mag_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      // one restoring step: bring down the next dividend bit
      trial   = {rem_ff, mag_ff[SUM_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      qbit    = (trial >= {1'b0, dvs_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W);
         rem_in  = '0;
         neg_in  = dividend[SUM_W-1];
         mag_in  = dividend[SUM_W-1] ? (SUM_W'(0) - SUM_W'(dividend)) : SUM_W'(dividend);
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[K_W-1:0] : trial[K_W-1:0];
         mag_in = {mag_ff[SUM_W-2:0], qbit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      mag_ff <= mag_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign q_signed = neg_ff ? (SUM_W'(0) - mag_ff) : mag_ff;
   assign quotient = Q_W'(q_signed);
   assign done     = done_ff;

endmodule

### design/avg_pool_1d_forward.sv
`timescale 1ns / 1ps
// A sample that closes no window passes S_READ and S_SUM and returns to S_IDLE; one that closes
// a window also runs the bit-serial divider in S_DIV and waits in S_DONE for the output register.
// One sample at a time: req_ready drops from accept until the item is finished, and a
// finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active high) restores kernel 2, stride 2, one channel and an empty row.
module avg_pool_1d_forward #(
   parameter int unsigned MAX_KERNEL   = apool_pkg::MAX_KERNEL_DEF,
   parameter int unsigned MAX_CHANNELS = apool_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [apool_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                  req_row_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [apool_pkg::SAMPLE_BITS-1:0] rsp_average,
   output logic [apool_pkg::CHAN_OUT_W-1:0]      rsp_channel,
   output logic [apool_pkg::POS_W-1:0]           rsp_window_index,
   output logic                                  rsp_row_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [apool_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [apool_pkg::CFG_W-1:0]           csr_data
);

   localparam int unsigned SB      = apool_pkg::SAMPLE_BITS;
   localparam int unsigned CFG_W   = apool_pkg::CFG_W;
   localparam int unsigned CHCNT_W = apool_pkg::CHCNT_W;
   localparam int unsigned POS_W   = apool_pkg::POS_W;
   localparam int unsigned PHASE_W = apool_pkg::PHASE_W;
   localparam int unsigned COUT_W  = apool_pkg::CHAN_OUT_W;
   localparam int unsigned RP_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int unsigned CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned SUM_W   = SB + $clog2(MAX_KERNEL);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_SUM  = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]   kernel_size_ff, stride_ff;
   logic [CHCNT_W-1:0] chan_count_ff;
   logic [CFG_W-1:0]   k_eff, s_eff;
   logic [CHCNT_W-1:0] nc_eff;

   logic [POS_W-1:0]   position_ff, window_count_ff, win_idx_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [CH_W-1:0]    chan_pos_ff, ch_ff, ch_cur;
   logic [RP_W-1:0]    ring_ptr_ff, ring_ptr_next, old_ptr;
   logic               last_ch_ff, last_ch_cur, row_end_ff;
   logic signed [SB-1:0] x_ff, old_ff;

   logic [SB-1:0]      ring_mem [MAX_CHANNELS][MAX_KERNEL];

   logic signed [SUM_W-1:0] wsum_ff [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] wsum_vld_ff;
   logic signed [SUM_W-1:0] sum_cur, sum_new;
   logic signed [SUM_W:0]   old_term, sum_wide;
   logic                    full, window_done, emit;

   logic                    rsp_valid_ff;
   logic signed [SB-1:0]    rsp_average_ff;
   logic [COUT_W-1:0]       rsp_channel_ff;
   logic [POS_W-1:0]        rsp_window_index_ff;
   logic                    rsp_row_last_ff;

   logic                    div_start, div_done;
   logic signed [SB-1:0]    div_q;

   logic req_fire, csr_fire, rsp_load, rsp_free;

   // Effective register values, out-of-range codes pinned to the legal range.
   always_comb begin
      if (kernel_size_ff == '0) k_eff = CFG_W'(1);
      else if (32'(kernel_size_ff) > MAX_KERNEL) k_eff = CFG_W'(MAX_KERNEL);
      else k_eff = kernel_size_ff;

      if (stride_ff == '0) s_eff = CFG_W'(1);
      else if (32'(stride_ff) > apool_pkg::MAX_STRIDE) s_eff = CFG_W'(apool_pkg::MAX_STRIDE);
      else s_eff = stride_ff;

      if (chan_count_ff == '0) nc_eff = CHCNT_W'(1);
      else if (32'(chan_count_ff) > MAX_CHANNELS) nc_eff = CHCNT_W'(MAX_CHANNELS);
      else nc_eff = chan_count_ff;
   end

   always_comb begin
      if (32'(chan_pos_ff) >= 32'(nc_eff)) ch_cur = CH_W'(nc_eff - CHCNT_W'(1));
      else ch_cur = chan_pos_ff;
      last_ch_cur = (32'(ch_cur) + 1 >= 32'(nc_eff));

      // slot that leaves the window: kernel positions behind the current one
      if (32'(ring_ptr_ff) >= 32'(k_eff)) old_ptr = RP_W'(32'(ring_ptr_ff) - 32'(k_eff));
      else old_ptr = RP_W'(32'(ring_ptr_ff) + MAX_KERNEL - 32'(k_eff));

      if (32'(ring_ptr_ff) + 1 == MAX_KERNEL) ring_ptr_next = '0;
      else ring_ptr_next = ring_ptr_ff + RP_W'(1);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   // Window sum update
   always_comb begin
      full        = (32'(position_ff) >= 32'(k_eff));
      window_done = (32'(position_ff) + 1 >= 32'(k_eff));
      emit        = window_done && (phase_ff == '0);
      sum_cur     = wsum_vld_ff[ch_ff] ? wsum_ff[ch_ff] : '0;
      old_term    = full ? (SUM_W+1)'(old_ff) : '0;
      sum_wide    = (SUM_W+1)'(sum_cur) + (SUM_W+1)'(x_ff) - old_term;
      sum_new     = SUM_W'(sum_wide);
   end

   assign div_start = (state_ff == S_SUM) && emit;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == S_DONE) && rsp_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_fire) state_in = S_READ;
         S_READ: state_in = S_SUM;
         S_SUM:  state_in = emit ? S_DIV : S_IDLE;
         S_DIV:  if (div_done) state_in = S_DONE;
         S_DONE: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Sample ring: in S_READ, read the departing slot and store the new sample in the same cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         old_ff <= ring_mem[ch_ff][old_ptr];
         ring_mem[ch_ff][ring_ptr_ff] <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff       <= req_sample;
         row_end_ff <= req_row_end;
         ch_ff      <= ch_cur;
         last_ch_ff <= last_ch_cur;
      end
      if (state_ff == S_SUM) begin
         wsum_ff[ch_ff] <= sum_new;
         win_idx_ff     <= window_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         kernel_size_ff  <= CFG_W'(2);
         stride_ff       <= CFG_W'(2);
         chan_count_ff   <= CHCNT_W'(1);
         wsum_vld_ff     <= '0;
         position_ff     <= '0;
         chan_pos_ff     <= '0;
         phase_ff        <= '0;
         window_count_ff <= '0;
         ring_ptr_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            case (csr_index)
               apool_pkg::REG_KERNEL_SIZE:   kernel_size_ff <= csr_data;
               apool_pkg::REG_STRIDE:        stride_ff      <= csr_data;
               apool_pkg::REG_CHANNEL_COUNT: chan_count_ff  <= CHCNT_W'(csr_data);
               default: ;
            endcase
            // a write to any of the three registers starts a fresh row
            if (csr_index == apool_pkg::REG_KERNEL_SIZE || csr_index == apool_pkg::REG_STRIDE
                || csr_index == apool_pkg::REG_CHANNEL_COUNT) begin
               wsum_vld_ff     <= '0;
               position_ff     <= '0;
               chan_pos_ff     <= '0;
               phase_ff        <= '0;
               window_count_ff <= '0;
            end
         end
         if (state_ff == S_SUM) begin
            if (row_end_ff) begin
               ring_ptr_ff     <= ring_ptr_next;
               wsum_vld_ff     <= '0;
               position_ff     <= '0;
               chan_pos_ff     <= '0;
               phase_ff        <= '0;
               window_count_ff <= '0;
            end else begin
               wsum_vld_ff[ch_ff] <= 1'b1;
               if (last_ch_ff) begin
                  if (window_done) begin
                     if (phase_ff == '0 && 32'(window_count_ff) < apool_pkg::MAX_WIDTH - 1)
                        window_count_ff <= window_count_ff + POS_W'(1);
                     if (32'(phase_ff) + 1 >= 32'(s_eff)) phase_ff <= '0;
                     else phase_ff <= phase_ff + PHASE_W'(1);
                  end
                  if (32'(position_ff) < apool_pkg::MAX_WIDTH - 1)
                     position_ff <= position_ff + POS_W'(1);
                  ring_ptr_ff <= ring_ptr_next;
                  chan_pos_ff <= '0;
               end else begin
                  chan_pos_ff <= ch_ff + CH_W'(1);
               end
            end
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_average_ff      <= div_q;
         rsp_channel_ff      <= COUT_W'(ch_ff);
         rsp_window_index_ff <= win_idx_ff;
         rsp_row_last_ff     <= row_end_ff;
      end
   end

   apool_div #(
      .SUM_W (SUM_W),
      .Q_W   (SB),
      .K_W   (CFG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (k_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_average      = rsp_average_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_window_index = rsp_window_index_ff;
   assign rsp_row_last     = rsp_row_last_ff;

endmodule

### design/apool_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the average pooling block, bound to the top level.
module apool_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic signed [apool_pkg::SAMPLE_BITS-1:0] req_sample,
   input logic                                  req_row_end,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [apool_pkg::SAMPLE_BITS-1:0] rsp_average,
   input logic [apool_pkg::CHAN_OUT_W-1:0]      rsp_channel,
   input logic [apool_pkg::POS_W-1:0]           rsp_window_index,
   input logic                                  rsp_row_last,
   input logic                                  csr_valid,
   input logic                                  csr_ready,
   input logic [apool_pkg::CSR_IDX_W-1:0]       csr_index,
   input logic [apool_pkg::CFG_W-1:0]           csr_data
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average) && $stable(rsp_channel)
         && $stable(rsp_window_index) && $stable(rsp_row_last))
      else $error("stalled result changed");

   // one sample at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // a result passes through the divider, so no result shows right after an accepted sample
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result too early after input");

   // first edge out of reset sees an idle block
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && req_ready && csr_ready)
      else $error("not idle after reset");

endmodule

bind avg_pool_1d_forward apool_checker u_apool_checker (.*);

### bench/avg_pool_checker.sv
`timescale 1ns / 1ps
// Checker for the 1-D average pooling block: tracks the stream, predicts averages, compares them.
module avg_pool_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic signed [apool_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                     req_row_end,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic signed [apool_pkg::SAMPLE_BITS-1:0] rsp_average,
   input  logic [apool_pkg::CHAN_OUT_W-1:0]         rsp_channel,
   input  logic [apool_pkg::POS_W-1:0]              rsp_window_index,
   input  logic                                     rsp_row_last,
   input  logic                                     csr_valid,
   input  logic                                     csr_ready,
   input  logic [apool_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [apool_pkg::CFG_W-1:0]              csr_data,
   output int                                       mismatch_count,
   output int                                       pending_results,
   output int                                       averages_checked
);

   localparam int unsigned SB         = apool_pkg::SAMPLE_BITS;
   localparam int unsigned CHAN_OUT_W = apool_pkg::CHAN_OUT_W;
   localparam int unsigned POS_W      = apool_pkg::POS_W;
   localparam int unsigned CSR_IDX_W  = apool_pkg::CSR_IDX_W;
   localparam int unsigned CFG_W      = apool_pkg::CFG_W;
   localparam int unsigned CHCNT_W    = apool_pkg::CHCNT_W;
   localparam int unsigned NCH        = apool_pkg::MAX_CHANNELS_DEF;
   localparam int unsigned NK         = apool_pkg::MAX_KERNEL_DEF;
   localparam int unsigned SLOT_W     = $clog2(NK);

   typedef struct {
      logic signed [SB-1:0]  average;
      logic [CHAN_OUT_W-1:0] channel;
      logic [POS_W-1:0]      window_index;
      logic                  row_last;
   } pool_result_type;

   pool_result_type due_averages[$];

   logic [CFG_W-1:0]   kernel_reg;
   logic [CFG_W-1:0]   stride_reg;
   logic [CHCNT_W-1:0] chcnt_reg;

   int          ring [NCH][NK];
   int          chan_sum [NCH];
   logic [SLOT_W-1:0] ring_slot;
   int unsigned row_pos;
   int unsigned chan_next;
   int unsigned phase_cnt;
   int unsigned win_count;
   int          mismatches = 0;
   int          checked = 0;

   function automatic int unsigned usable(int unsigned raw, int unsigned limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

   task automatic clear_row();
      foreach (chan_sum[i]) chan_sum[i] = 0;
      row_pos   = 0;
      chan_next = 0;
      phase_cnt = 0;
      win_count = 0;
   endtask

   task automatic write_model_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      case (idx)
         apool_pkg::REG_KERNEL_SIZE: begin
            kernel_reg = data;
            clear_row();
         end
         apool_pkg::REG_STRIDE: begin
            stride_reg = data;
            clear_row();
         end
         apool_pkg::REG_CHANNEL_COUNT: begin
            chcnt_reg = data[CHCNT_W-1:0];
            clear_row();
         end
         default: ;
      endcase
   endtask

   task automatic pool_step(input logic signed [SB-1:0] x, input logic row_end);
      int unsigned k, s, nc, ch;
      logic [SLOT_W-1:0] old_slot;
      pool_result_type r;
      k  = usable(32'(kernel_reg), NK);
      s  = usable(32'(stride_reg), apool_pkg::MAX_STRIDE);
      nc = usable(32'(chcnt_reg), NCH);
      ch = (chan_next >= nc) ? nc - 1 : chan_next;
      // the sample leaving the window sits k slots back in the ring
      old_slot = ring_slot - SLOT_W'(k);
      if (row_pos >= k) chan_sum[ch] -= ring[ch][old_slot];
      chan_sum[ch] += int'(x);
      ring[ch][ring_slot] = int'(x);
      if (row_pos + 1 >= k && phase_cnt == 0) begin
         r.average      = 16'(chan_sum[ch] / int'(k));
         r.channel      = CHAN_OUT_W'(ch);
         r.window_index = POS_W'(win_count);
         r.row_last     = row_end;
         due_averages.push_back(r);
      end
      if (row_end) begin
         ring_slot++;
         clear_row();
      end else if (ch + 1 >= nc) begin
         if (row_pos + 1 >= k) begin
            if (phase_cnt == 0 && win_count < apool_pkg::MAX_WIDTH - 1) win_count++;
            phase_cnt = (phase_cnt + 1 >= s) ? 0 : phase_cnt + 1;
         end
         if (row_pos < apool_pkg::MAX_WIDTH - 1) row_pos++;
         ring_slot++;
         chan_next = 0;
      end else begin
         chan_next = ch + 1;
      end
   endtask

   task automatic check_average();
      pool_result_type want;
      if (due_averages.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected average: avg %0d ch %0d win %0d last %0b",
                     rsp_average, rsp_channel, rsp_window_index, rsp_row_last);
      end else begin
         want = due_averages.pop_front();
         checked++;
         if (rsp_average !== want.average || rsp_channel !== want.channel ||
             rsp_window_index !== want.window_index || rsp_row_last !== want.row_last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("average mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                        want.average, want.channel, want.window_index, want.row_last,
                        rsp_average, rsp_channel, rsp_window_index, rsp_row_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kernel_reg = 7'd2;
         stride_reg = 7'd2;
         chcnt_reg  = 5'd1;
         ring_slot  = '0;
         clear_row();
         due_averages.delete();
      end else begin
         // results leave before the sample of this edge can add a new one
         if (rsp_valid && rsp_ready) check_average();
         if (csr_valid && csr_ready) write_model_reg(csr_index, csr_data);
         if (req_valid && req_ready) pool_step(req_sample, req_row_end);
      end
      pending_results  <= due_averages.size();
      mismatch_count   <= mismatches;
      averages_checked <= checked;
   end

endmodule

### bench/avg_pool_1d_forward_test.sv
`timescale 1ns / 1ps
// Top of the pooling testbench: clock, reset, sample and register stimulus, verdict.
module avg_pool_1d_forward_test;

   localparam int unsigned SB        = apool_pkg::SAMPLE_BITS;
   localparam int unsigned CFG_W     = apool_pkg::CFG_W;
   localparam int unsigned CSR_IDX_W = apool_pkg::CSR_IDX_W;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_ITEMS    = 530;
   localparam int LONG_ROW       = 150;

   typedef enum {FILL_MAX, FILL_MIN, FILL_SMALL, FILL_EXTREME, FILL_RANDOM} fill_kind_type;

   typedef struct {
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     data;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid   = 1'b0;
   logic                               req_ready;
   logic signed [SB-1:0]               req_sample  = '0;
   logic                               req_row_end = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready   = 1'b0;
   logic signed [SB-1:0]               rsp_average;
   logic [apool_pkg::CHAN_OUT_W-1:0]   rsp_channel;
   logic [apool_pkg::POS_W-1:0]        rsp_window_index;
   logic                               rsp_row_last;
   logic                               csr_valid   = 1'b0;
   logic                               csr_ready;
   logic [CSR_IDX_W-1:0]               csr_index   = '0;
   logic [CFG_W-1:0]                   csr_data    = '0;

   int mismatch_count;
   int pending_results;
   int averages_checked;
   int send_idle_pct = 32;
   int recv_idle_pct = 85;
   int samples_sent  = 0;
   int regs_written  = 0;
   int stall_cycles  = 0;

   reg_write_type reg_queue[$];

   avg_pool_1d_forward i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_row_end      (req_row_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_channel      (rsp_channel),
      .rsp_window_index (rsp_window_index),
      .rsp_row_last     (rsp_row_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   avg_pool_checker i_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_row_end      (req_row_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_channel      (rsp_channel),
      .rsp_window_index (rsp_window_index),
      .rsp_row_last     (rsp_row_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results),
      .averages_checked (averages_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   function automatic int unsigned usable(int unsigned raw, int unsigned mask,
                                          int unsigned limit);
      int unsigned v;
      v = raw & mask;
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic logic [CFG_W-1:0] boundary_code(int unsigned limit);
      case ($urandom_range(0, 3))
         0: return CFG_W'($urandom_range(0, 1));
         1: return CFG_W'(limit);
         2: return CFG_W'($urandom_range(limit + 1, 127));
         default: return CFG_W'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic logic signed [SB-1:0] pick_sample(fill_kind_type fill);
      case (fill)
         FILL_MAX:     return 16'sh7FFF;
         FILL_MIN:     return 16'sh8000;
         FILL_SMALL:   return 16'($signed($urandom_range(0, 16)) - 8);
         FILL_EXTREME: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default:      return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic signed [SB-1:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= value;
      req_row_end <= last;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   // hold off the sender until every average is back, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      reg_write_type w;
      w.idx  = idx;
      w.data = data;
      reg_queue.push_back(w);
   endtask

   task automatic apply_regs();
      reg_write_type w;
      settle();
      while (reg_queue.size() > 0) begin
         w = reg_queue.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.idx;
         csr_data  <= w.data;
         do @(posedge clock); while (!csr_ready);
         regs_written++;
      end
      csr_valid <= 1'b0;
   endtask

   // broken rows end at an arbitrary sample; open rows carry no row end at all
   task automatic send_row(int unsigned positions, int unsigned channels, bit broken,
                           bit open_end);
      fill_kind_type fill;
      int unsigned   total, n;
      fill  = ($urandom_range(0, 9) < 5) ? FILL_RANDOM : fill_kind_type'($urandom_range(0, 3));
      total = positions * channels;
      if (broken) total = $urandom_range(1, total);
      for (n = 0; n < total; n++)
         send_sample(pick_sample(fill), !open_end && n == total - 1);
   endtask

   initial begin
      int unsigned k_eff, s_eff, nc_eff, positions, rows, r;
      logic [CFG_W-1:0] k_raw, s_raw, n_raw;
      int idle_phase;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: kernel 2, stride 2, one channel; full-scale sums and rounding to zero
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0001, 1'b0);
      send_sample(-16'sd2, 1'b1);
      // row shorter than the kernel
      send_sample(16'sd5, 1'b1);

      set_reg(apool_pkg::REG_KERNEL_SIZE, 7'd3);
      set_reg(apool_pkg::REG_STRIDE, 7'd1);
      set_reg(apool_pkg::REG_CHANNEL_COUNT, 7'd3);
      apply_regs();
      send_sample(-16'sd4, 1'b0);
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd1, 1'b0);
      // write to the unused index mid-row: must leave the row alone
      set_reg(REG_SPARE, 7'h55);
      apply_regs();
      send_sample(-16'sd2, 1'b0);
      send_sample(16'sd200, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd300, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sd9, 1'b0);
      // row end in the middle of a position
      send_sample(16'sd1, 1'b1);

      // zero registers act as one
      set_reg(apool_pkg::REG_KERNEL_SIZE, 7'd0);
      set_reg(apool_pkg::REG_STRIDE, 7'd0);
      set_reg(apool_pkg::REG_CHANNEL_COUNT, 7'd0);
      apply_regs();
      send_sample(-16'sd7, 1'b0);
      send_sample(16'sd7, 1'b0);
      send_sample(16'sh8000, 1'b1);

      // oversized registers clamp to their maximum
      set_reg(apool_pkg::REG_KERNEL_SIZE, 7'h7F);
      set_reg(apool_pkg::REG_STRIDE, 7'h7F);
      set_reg(apool_pkg::REG_CHANNEL_COUNT, 7'h7F);
      apply_regs();
      send_sample(16'sd1234, 1'b0);
      send_sample(-16'sd1234, 1'b1);

      for (idle_phase = 0; idle_phase < 3; idle_phase++) begin
         case (idle_phase)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (samples_sent < (idle_phase + 1) * PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
               k_raw = CFG_W'($urandom_range(1, 8));
               s_raw = CFG_W'($urandom_range(1, 8));
               n_raw = CFG_W'($urandom_range(1, 4));
            end else begin
               k_raw = boundary_code(apool_pkg::MAX_KERNEL_DEF);
               s_raw = boundary_code(apool_pkg::MAX_STRIDE);
               n_raw = boundary_code(apool_pkg::MAX_CHANNELS_DEF);
            end
            set_reg(apool_pkg::REG_KERNEL_SIZE, k_raw);
            set_reg(apool_pkg::REG_STRIDE, s_raw);
            set_reg(apool_pkg::REG_CHANNEL_COUNT, n_raw);
            if ($urandom_range(0, 9) == 0) set_reg(REG_SPARE, CFG_W'($urandom_range(0, 127)));
            apply_regs();
            k_eff  = usable(32'(k_raw), 32'h7F, apool_pkg::MAX_KERNEL_DEF);
            s_eff  = usable(32'(s_raw), 32'h7F, apool_pkg::MAX_STRIDE);
            nc_eff = usable(32'(n_raw), 32'h1F, apool_pkg::MAX_CHANNELS_DEF);
            rows   = $urandom_range(1, 3);
            for (r = 0; r < rows; r++) begin
               if (k_eff * nc_eff <= 256)
                  positions = k_eff + $urandom_range(0, 3 * s_eff);
               else
                  positions = $urandom_range(1, 256 / nc_eff);
               if (positions * nc_eff > 320) positions = 320 / nc_eff;
               send_row(positions, nc_eff, $urandom_range(0, 9) == 0,
                        r == rows - 1 && $urandom_range(0, 4) == 0);
            end
         end
      end

      // one unbroken row with kernel and stride of one: a result for every sample
      set_reg(apool_pkg::REG_KERNEL_SIZE, 7'd1);
      set_reg(apool_pkg::REG_STRIDE, 7'd1);
      set_reg(apool_pkg::REG_CHANNEL_COUNT, 7'd1);
      apply_regs();
      for (r = 0; r < LONG_ROW; r++)
         send_sample(pick_sample(FILL_RANDOM), r == LONG_ROW - 1);

      settle();
      $display("%0d samples sent, %0d averages checked, %0d register writes",
               samples_sent, averages_checked, regs_written);
      $display("covered clamped and extreme registers, broken and open rows, dense results");
      if (mismatch_count == 0 && pending_results == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### filelist.f
design/apool_pkg.sv
design/apool_div.sv
design/avg_pool_1d_forward.sv
design/apool_checker.sv
bench/avg_pool_checker.sv
bench/avg_pool_1d_forward_test.sv
